>>> hw/rtl/apsp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the shortest path block.
package apsp_pkg;

  // Default sizes for the top level parameters.
  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned DIST_BITS_DEF = 16;

  // Fixed port field widths.
  localparam int unsigned NODE_BITS = 6;
  localparam int unsigned LEN_BITS  = 16;
  localparam int unsigned VIA_BITS  = 6;
  localparam int unsigned CFG_BITS  = 7;

  // Node count register value after reset.
  localparam logic [CFG_BITS-1:0] NODE_COUNT_RST = 7'd64;

  // Item function codes.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_RUN_ROW,
    S_RUN_IK,
    S_RUN_RD,
    S_RUN_UPD,
    S_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_item;
    logic wr_item;
    logic rd_item;
    logic rd_ik;
    logic latch_ik;
    logic rd_pair;
    logic upd_pair;
    logic col_inc;
    logic col_clr;
    logic row_inc;
    logic row_clr;
    logic piv_inc;
    logic piv_clr;
    logic ld_out;
  } apsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic col_last;
    logic row_last;
    logic piv_last;
    logic cnt_zero;
    logic out_free;
  } apsp_stat_t;

endpackage

>>> hw/rtl/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest path block: controller plus datapath.
//
// A write item stores one distance and sets its via node to the column; a read
// item returns one distance and via node; a run item relaxes all pairs through
// every pivot in index order with saturating sums (all ones is infinity) and
// answers with run_done. A write or read item passes from idle through its own
// state to the finish state, which loads the result into the output register,
// and the block is then idle and ready again. In a run, each row of each pivot
// first fetches the row's distance to the pivot and latches it, and each
// relaxation then reads the pivot-row and pair entries from the distance
// memory and afterwards adds, compares and writes back. One item is in
// progress at a time; a finished result is held in an output register, and
// the next item is accepted while it waits. An item that finishes while the
// earlier result is still not taken waits until that result leaves. The
// memories are not cleared at reset, so every entry in use must be written
// before it is run over or read.
module all_pairs_shortest_path #(
  parameter int unsigned MAX_NODES = apsp_pkg::MAX_NODES_DEF,
  parameter int unsigned DIST_BITS = apsp_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic [apsp_pkg::NODE_BITS-1:0] in_row_node,
  input  logic [apsp_pkg::NODE_BITS-1:0] in_col_node,
  input  logic [apsp_pkg::LEN_BITS-1:0]  in_edge_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [apsp_pkg::LEN_BITS-1:0]  out_path_length,
  output logic [apsp_pkg::VIA_BITS-1:0]  out_via_node,
  output logic                           out_run_done,
  input  logic                           cfg_wr_en,
  input  logic [apsp_pkg::CFG_BITS-1:0]  cfg_wr_data
);

  apsp_pkg::apsp_cmd_t  cmd;
  apsp_pkg::apsp_stat_t stat;

  // Sequencer.
  apsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  apsp_datapath #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_row_node     (in_row_node),
    .in_col_node     (in_col_node),
    .in_edge_length  (in_edge_length),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_path_length (out_path_length),
    .out_via_node    (out_via_node),
    .out_run_done    (out_run_done)
  );

endmodule

>>> hw/rtl/apsp_ctrl.sv
// Controller state machine that sequences writes, reads and the relaxation run.
module apsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_func,
  input  apsp_pkg::apsp_stat_t stat,
  output logic                in_ready,
  output apsp_pkg::apsp_cmd_t  cmd
);

  apsp_pkg::ctrl_state_t state_r;
  apsp_pkg::ctrl_state_t state_nxt;
  logic                  accept;

  assign accept = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apsp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      apsp_pkg::S_IDLE: begin
        // The block is always ready here, so a valid item is taken at once.
        in_ready    = 1'b1;
        cmd.ld_item = in_valid;
        if (in_valid) begin
          priority if (in_func == apsp_pkg::FUNC_WRITE) begin
            state_nxt = apsp_pkg::S_WRITE;
          end else if (in_func == apsp_pkg::FUNC_READ) begin
            state_nxt = apsp_pkg::S_READ;
          end else if (in_func == apsp_pkg::FUNC_RUN && !stat.n_zero) begin
            state_nxt = apsp_pkg::S_RUN_ROW;
          end else begin
            state_nxt = apsp_pkg::S_FINISH;
          end
        end
      end
      apsp_pkg::S_WRITE: begin
        cmd.wr_item = 1'b1;
        state_nxt   = apsp_pkg::S_FINISH;
      end
      apsp_pkg::S_READ: begin
        cmd.rd_item = 1'b1;
        state_nxt   = apsp_pkg::S_FINISH;
      end
      apsp_pkg::S_RUN_ROW: begin
        cmd.rd_ik = 1'b1;
        state_nxt = apsp_pkg::S_RUN_IK;
      end
      apsp_pkg::S_RUN_IK: begin
        cmd.latch_ik = 1'b1;
        state_nxt    = apsp_pkg::S_RUN_RD;
      end
      apsp_pkg::S_RUN_RD: begin
        cmd.rd_pair = 1'b1;
        state_nxt   = apsp_pkg::S_RUN_UPD;
      end
      apsp_pkg::S_RUN_UPD: begin
        cmd.upd_pair = 1'b1;
        // Advance column, then row, then pivot.
        if (!stat.col_last) begin
          cmd.col_inc = 1'b1;
          state_nxt   = apsp_pkg::S_RUN_RD;
        end else if (!stat.row_last) begin
          cmd.col_clr = 1'b1;
          cmd.row_inc = 1'b1;
          state_nxt   = apsp_pkg::S_RUN_ROW;
        end else if (!stat.piv_last) begin
          cmd.col_clr = 1'b1;
          cmd.row_clr = 1'b1;
          cmd.piv_inc = 1'b1;
          state_nxt   = apsp_pkg::S_RUN_ROW;
        end else begin
          cmd.col_clr = 1'b1;
          cmd.row_clr = 1'b1;
          cmd.piv_clr = 1'b1;
          state_nxt   = apsp_pkg::S_FINISH;
        end
      end
      apsp_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = apsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = apsp_pkg::S_IDLE;
      end
    endcase
  end

  // The run counters are back at zero whenever no item is in progress.
  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apsp_pkg::S_IDLE) |-> stat.cnt_zero)
    else $error("run counters not cleared while idle");

  // A run over at least one node starts with a row fetch.
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == apsp_pkg::FUNC_RUN && !stat.n_zero)
      |=> (state_r == apsp_pkg::S_RUN_ROW))
    else $error("run item did not start the relaxation");

  // The last relaxation of a run leads to the result.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apsp_pkg::S_RUN_UPD && stat.col_last && stat.row_last && stat.piv_last)
      |=> (state_r == apsp_pkg::S_FINISH))
    else $error("run did not finish after the last relaxation");

  // Handing over a result frees the block for the next item.
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apsp_pkg::S_FINISH && stat.out_free) |=> (state_r == apsp_pkg::S_IDLE))
    else $error("result handed over but block not idle");

endmodule

>>> hw/rtl/apsp_datapath.sv
// Datapath: distance and via memories, run counters, saturating relaxation and output register.
module apsp_datapath #(
  parameter int unsigned MAX_NODES = apsp_pkg::MAX_NODES_DEF,
  parameter int unsigned DIST_BITS = apsp_pkg::DIST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  apsp_pkg::apsp_cmd_t                 cmd,
  output apsp_pkg::apsp_stat_t                stat,
  input  logic [1:0]                          in_func,
  input  logic [apsp_pkg::NODE_BITS-1:0]      in_row_node,
  input  logic [apsp_pkg::NODE_BITS-1:0]      in_col_node,
  input  logic [apsp_pkg::LEN_BITS-1:0]       in_edge_length,
  input  logic                                cfg_wr_en,
  input  logic [apsp_pkg::CFG_BITS-1:0]       cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [apsp_pkg::LEN_BITS-1:0]       out_path_length,
  output logic [apsp_pkg::VIA_BITS-1:0]       out_via_node,
  output logic                                out_run_done
);

  localparam int unsigned IDX_W  = $clog2(MAX_NODES);
  localparam int unsigned AW     = 2 * IDX_W;
  localparam int unsigned DEPTH  = 1 << AW;
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned NW     = (CNT_W > apsp_pkg::CFG_BITS) ? CNT_W : apsp_pkg::CFG_BITS;
  localparam logic [DIST_BITS-1:0] INF = '1;

  // Configuration register.
  logic [apsp_pkg::CFG_BITS-1:0] node_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= apsp_pkg::NODE_COUNT_RST;
    end else if (cfg_wr_en) begin
      node_cnt_r <= cfg_wr_data;
    end
  end

  // Node count clamped to the storage size, and the last index of a run.
  logic [NW-1:0]    n_sat;
  logic [NW-1:0]    n_wide;
  logic [IDX_W-1:0] last_idx;

  assign n_wide   = NW'(node_cnt_r);
  assign n_sat    = (n_wide > NW'(MAX_NODES)) ? NW'(MAX_NODES) : n_wide;
  assign last_idx = IDX_W'(n_sat - NW'(1));

  // Item payload registers.
  logic [1:0]                     func_r;
  logic [apsp_pkg::NODE_BITS-1:0] row_r;
  logic [apsp_pkg::NODE_BITS-1:0] col_r;
  logic [DIST_BITS-1:0]           len_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      func_r <= in_func;
      row_r  <= in_row_node;
      col_r  <= in_col_node;
      len_r  <= DIST_BITS'(in_edge_length);
    end
  end

  // An entry outside the store is ignored on write and reads as zero.
  logic             item_ok;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;

  assign item_ok = (32'(row_r) < MAX_NODES) && (32'(col_r) < MAX_NODES);
  assign row_idx = IDX_W'(row_r);
  assign col_idx = IDX_W'(col_r);

  // Run counters.
  logic [IDX_W-1:0] piv_r;
  logic [IDX_W-1:0] row_cnt_r;
  logic [IDX_W-1:0] col_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piv_r     <= '0;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      if (cmd.piv_clr) begin
        piv_r <= '0;
      end else if (cmd.piv_inc) begin
        piv_r <= piv_r + IDX_W'(1);
      end
      if (cmd.row_clr) begin
        row_cnt_r <= '0;
      end else if (cmd.row_inc) begin
        row_cnt_r <= row_cnt_r + IDX_W'(1);
      end
      if (cmd.col_clr) begin
        col_cnt_r <= '0;
      end else if (cmd.col_inc) begin
        col_cnt_r <= col_cnt_r + IDX_W'(1);
      end
    end
  end

  // Memory ports.
  logic [DIST_BITS-1:0]          dist_mem [DEPTH];
  logic [apsp_pkg::VIA_BITS-1:0] via_mem  [DEPTH];
  logic [DIST_BITS-1:0]          rd_a_r;
  logic [DIST_BITS-1:0]          rd_b_r;
  logic [apsp_pkg::VIA_BITS-1:0] via_rd_r;
  logic [DIST_BITS-1:0]          dik_r;
  logic [AW-1:0]                 addr_a;
  logic [AW-1:0]                 addr_b;
  logic [AW-1:0]                 wr_addr;
  logic                          rd_a_en;
  logic                          wr_en;
  logic [DIST_BITS-1:0]          wr_dist;
  logic [apsp_pkg::VIA_BITS-1:0] wr_via;

  // Relaxation: saturating sum through the pivot against the current entry.
  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] sum_sat;
  logic                 better;

  assign sum     = {1'b0, dik_r} + {1'b0, rd_a_r};
  assign sum_sat = (sum >= {1'b0, INF}) ? INF : sum[DIST_BITS-1:0];
  assign better  = sum_sat < rd_b_r;

  // Address and write data selection.
  always_comb begin
    if (cmd.rd_ik) begin
      addr_a = {row_cnt_r, piv_r};
    end else if (cmd.rd_pair) begin
      addr_a = {piv_r, col_cnt_r};
    end else begin
      addr_a = {row_idx, col_idx};
    end
  end

  assign addr_b  = {row_cnt_r, col_cnt_r};
  assign rd_a_en = cmd.rd_item || cmd.rd_ik || cmd.rd_pair;
  assign wr_en   = (cmd.wr_item && item_ok) || (cmd.upd_pair && better);
  assign wr_addr = cmd.upd_pair ? {row_cnt_r, col_cnt_r} : {row_idx, col_idx};
  assign wr_dist = cmd.upd_pair ? sum_sat : len_r;
  assign wr_via  = cmd.upd_pair ? apsp_pkg::VIA_BITS'(piv_r) : apsp_pkg::VIA_BITS'(col_r);

  // Distance and via memories, one write and registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
      via_mem[wr_addr]  <= wr_via;
    end
    if (rd_a_en) begin
      rd_a_r   <= dist_mem[addr_a];
      via_rd_r <= via_mem[addr_a];
    end
    if (cmd.rd_pair) begin
      rd_b_r <= dist_mem[addr_b];
    end
  end

  // Row distance to the pivot, held for the whole row.
  always_ff @(posedge clk) begin
    if (cmd.latch_ik) begin
      dik_r <= rd_a_r;
    end
  end

  // Output register.
  logic                          out_valid_r;
  logic [apsp_pkg::LEN_BITS-1:0] out_len_r;
  logic [apsp_pkg::VIA_BITS-1:0] out_via_r;
  logic                          out_run_r;
  logic                          rd_hit;

  assign rd_hit = (func_r == apsp_pkg::FUNC_READ) && item_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_len_r <= rd_hit ? apsp_pkg::LEN_BITS'(rd_a_r) : '0;
      out_via_r <= rd_hit ? via_rd_r : '0;
      out_run_r <= (func_r == apsp_pkg::FUNC_RUN);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_path_length = out_len_r;
  assign out_via_node    = out_via_r;
  assign out_run_done    = out_run_r;

  // Status toward the controller.
  assign stat.n_zero   = (n_sat == '0);
  assign stat.col_last = (col_cnt_r == last_idx);
  assign stat.row_last = (row_cnt_r == last_idx);
  assign stat.piv_last = (piv_r == last_idx);
  assign stat.cnt_zero = (piv_r == '0) && (row_cnt_r == '0) && (col_cnt_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule
